### hw/rtl/circle_pair_collision_test_defines.svh
// Assertion macros shared by the circle pair collision test RTL.
`ifndef CIRCLE_PAIR_COLLISION_TEST_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_TEST_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CPCT_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CPCT_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/cpct_pkg.sv
// Shared constants, types and helpers of the circle pair collision test.
`default_nettype none
package cpct_pkg;

    localparam int ANGLE_FRAC_BITS = 12;
    localparam int ANG_INT_BITS    = 16;
    localparam int ANG_SHIFT       = ANG_INT_BITS - ANGLE_FRAC_BITS;
    localparam int CORDIC_STEPS    = 16;
    localparam int SQRT_STEPS      = 33;
    localparam int LEN_W           = 41;
    localparam int ROT_W           = 42;
    localparam int XW              = 36;
    localparam int ZW              = 21;
    localparam int VEC_LAT         = CORDIC_STEPS + 3;

    localparam logic [21:0] INVK_Q22 = 22'd2547003;
    localparam logic signed [ZW-1:0] PI_Q16      = 21'sd205887;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 21'sd102944;

    typedef enum logic [1:0] {
        QUAD_NONE,
        QUAD_POS,
        QUAD_NEG
    } quad_t;

    typedef struct packed {
        logic [CORDIC_STEPS-1:0] dir;
        quad_t                   quad;
    } ctl_t;

    localparam logic signed [ROT_W-1:0] SAT_HI = ROT_W'(64'sd2147483647);
    localparam logic signed [ROT_W-1:0] SAT_LO = -ROT_W'(64'sd2147483648);

    function automatic logic signed [31:0] sat32(input logic signed [ROT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            4'd0:    r = 21'sd51472;
            4'd1:    r = 21'sd30386;
            4'd2:    r = 21'sd16055;
            4'd3:    r = 21'sd8150;
            4'd4:    r = 21'sd4091;
            4'd5:    r = 21'sd2047;
            4'd6:    r = 21'sd1024;
            4'd7:    r = 21'sd512;
            4'd8:    r = 21'sd256;
            4'd9:    r = 21'sd128;
            4'd10:   r = 21'sd64;
            4'd11:   r = 21'sd32;
            4'd12:   r = 21'sd16;
            4'd13:   r = 21'sd8;
            4'd14:   r = 21'sd4;
            default: r = 21'sd2;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/cpct_vec_rotate.sv
// Length scaling by 1/K and CORDIC rotation of one contact vector.
`default_nettype none
module cpct_vec_rotate import cpct_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [LEN_W-1:0] len_in,
    input  ctl_t                    ctl_in,
    output logic signed [31:0]      vec_x,
    output logic signed [31:0]      vec_y
);

    localparam int MAG_W  = LEN_W - 1;
    localparam int HALF_W = MAG_W / 2;
    localparam int PROD_W = HALF_W + 22;
    localparam int SUM_W  = PROD_W + HALF_W;

    logic [PROD_W-1:0]       ph_reg, ph_next, pl_reg, pl_next;
    logic                    neg_reg;
    logic signed [ROT_W-1:0] len_b_reg, len_b_next;
    ctl_t                    ctl_reg [CORDIC_STEPS+2];
    logic signed [ROT_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [ROT_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [ROT_W-1:0] x_next [CORDIC_STEPS];
    logic signed [ROT_W-1:0] y_next [CORDIC_STEPS];
    logic signed [ROT_W-1:0] fx, fy;

    // split the magnitude so each product stays narrow
    always_comb begin
        logic signed [LEN_W-1:0] mag;
        mag     = (len_in < 0) ? -len_in : len_in;
        ph_next = PROD_W'(mag[MAG_W-1:HALF_W]) * PROD_W'(INVK_Q22);
        pl_next = PROD_W'(mag[HALF_W-1:0]) * PROD_W'(INVK_Q22);
    end

    always_comb begin
        logic [SUM_W-1:0]        sum;
        logic signed [ROT_W-1:0] mext;
        sum  = (SUM_W'(ph_reg) << HALF_W) + SUM_W'(pl_reg) + (SUM_W'(1) << 21);
        mext = ROT_W'(sum[SUM_W-1:22]);
        len_b_next = neg_reg ? -mext : mext;
    end

    always_comb begin
        logic signed [ROT_W-1:0] xi, yi;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xi = (i == 0) ? len_b_reg : x_reg[(i == 0) ? 0 : i - 1];
            yi = (i == 0) ? '0 : y_reg[(i == 0) ? 0 : i - 1];
            if (ctl_reg[i+1].dir[i]) begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
            end else begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
            end
        end
    end

    // apply the quarter turn taken out before vectoring
    always_comb begin
        case (ctl_reg[CORDIC_STEPS+1].quad)
            QUAD_POS: begin
                fx = -y_reg[CORDIC_STEPS-1];
                fy = x_reg[CORDIC_STEPS-1];
            end
            QUAD_NEG: begin
                fx = y_reg[CORDIC_STEPS-1];
                fy = -x_reg[CORDIC_STEPS-1];
            end
            default: begin
                fx = x_reg[CORDIC_STEPS-1];
                fy = y_reg[CORDIC_STEPS-1];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg     <= ph_next;
            pl_reg     <= pl_next;
            neg_reg    <= (len_in < 0);
            len_b_reg  <= len_b_next;
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < CORDIC_STEPS + 2; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
            end
            vec_x <= sat32(fx);
            vec_y <= sat32(fy);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/circle_pair_collision_test.sv
// Top level of the circle pair collision test pipeline.
`default_nettype none
`include "circle_pair_collision_test_defines.svh"
// Narrow-phase test of one circle pair per item. The block is fully pipelined:
// it takes one item every cycle while the output is not stalled and returns
// each result in order. The pipeline holds the square root of the squared
// centre distance (33 stages, one result bit each, with the 16 CORDIC
// vectoring steps riding along), the contact vector rotators (2 scaling
// stages, 16 rotation steps, 1 saturation stage) and stages for subtraction,
// multiplication and output. A stalled output holds the whole pipeline;
// s_ready is low only while a result waits and m_ready is low.
// No state links one item to the next and no clearing pass follows reset.
module circle_pair_collision_test import cpct_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_this_x,
    input  logic signed [31:0] s_this_y,
    input  logic [30:0]        s_this_radius,
    input  logic [15:0]        s_this_scale_x,
    input  logic [15:0]        s_this_scale_y,
    input  logic signed [31:0] s_other_x,
    input  logic signed [31:0] s_other_y,
    input  logic [30:0]        s_other_radius,
    input  logic [15:0]        s_other_scale_x,
    input  logic [15:0]        s_other_scale_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic signed [31:0] m_first_contact_x,
    output logic signed [31:0] m_first_contact_y,
    output logic signed [15:0] m_first_angle,
    output logic signed [31:0] m_second_contact_x,
    output logic signed [31:0] m_second_contact_y,
    output logic signed [15:0] m_second_angle
);

    localparam int NSTG = SQRT_STEPS + VEC_LAT + 6;
    localparam logic signed [ZW-1:0] ANG_MAX = ZW'(32767);
    localparam logic signed [ZW-1:0] ANG_MIN = -ZW'(32768);

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               coin;
        logic [30:0]        trad;
        logic [30:0]        orad;
        logic [16:0]        tsum;
        logic [16:0]        osum;
    } f1_t;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [32:0]        adx;
        logic [32:0]        ady;
        logic               coin;
        logic [30:0]        trad;
        logic [47:0]        eff_t;
        logic [47:0]        eff_o;
    } f2_t;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [31:0]        x11;
        logic [31:0]        y11;
        logic [32:0]        x10;
        logic [32:0]        y10;
        logic [33:0]        x00;
        logic [33:0]        y00;
        logic               coin;
        logic [30:0]        trad;
        logic [38:0]        eff_t;
        logic [38:0]        eff_o;
    } f3_t;

    typedef struct packed {
        logic [65:0]          rad;
        logic [34:0]          rem;
        logic [32:0]          root;
        logic signed [XW-1:0] cx;
        logic signed [XW-1:0] cy;
        logic signed [ZW-1:0] z;
        ctl_t                 ctl;
        logic                 coin;
        logic [30:0]          trad;
        logic [38:0]          eff_t;
        logic [38:0]          eff_o;
    } st_t;

    typedef struct packed {
        logic                    hit;
        logic                    coin;
        logic signed [15:0]      a1;
        logic signed [15:0]      a2;
        logic signed [31:0]      c1;
        logic signed [31:0]      c2;
        logic signed [LEN_W-1:0] len1;
        logic signed [LEN_W-1:0] len2;
        ctl_t                    ctl;
    } h_t;

    typedef struct packed {
        logic               hit;
        logic               coin;
        logic signed [15:0] a1;
        logic signed [15:0] a2;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
    } side_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [15:0] a1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [15:0] a2;
    } res_t;

    function automatic logic signed [15:0] round_ang(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] t;
        logic signed [ZW-1:0] v;
        logic signed [15:0]   r;
        t = z + ZW'(1 << (ANG_SHIFT - 1));
        v = t >>> ANG_SHIFT;
        if (v > ANG_MAX) begin
            r = 16'sh7FFF;
        end else if (v < ANG_MIN) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic                    en;
    logic [NSTG-1:0]         vld_reg;
    f1_t                     f1_reg, f1_next;
    f2_t                     f2_reg, f2_next;
    f3_t                     f3_reg, f3_next;
    st_t                     st_reg [SQRT_STEPS+1];
    st_t                     st_next [SQRT_STEPS+1];
    h_t                      h_reg, h_next;
    side_t                   side_reg [VEC_LAT];
    res_t                    out_reg, out_next;
    logic signed [31:0]      v1x, v1y, v2x, v2y;

    // advance everything together; hold on a stalled result
    assign en      = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NSTG-1];

    always_comb begin
        f1_next.dx   = 33'(s_other_x) - 33'(s_this_x);
        f1_next.dy   = 33'(s_other_y) - 33'(s_this_y);
        f1_next.coin = (s_other_x == s_this_x) && (s_other_y == s_this_y);
        f1_next.trad = s_this_radius;
        f1_next.orad = s_other_radius;
        f1_next.tsum = 17'(s_this_scale_x) + 17'(s_this_scale_y);
        f1_next.osum = 17'(s_other_scale_x) + 17'(s_other_scale_y);
    end

    always_comb begin
        f2_next.dx    = f1_reg.dx;
        f2_next.dy    = f1_reg.dy;
        f2_next.adx   = (f1_reg.dx < 0) ? 33'(-f1_reg.dx) : 33'(f1_reg.dx);
        f2_next.ady   = (f1_reg.dy < 0) ? 33'(-f1_reg.dy) : 33'(f1_reg.dy);
        f2_next.coin  = f1_reg.coin;
        f2_next.trad  = f1_reg.trad;
        f2_next.eff_t = 48'(f1_reg.trad) * 48'(f1_reg.tsum);
        f2_next.eff_o = 48'(f1_reg.orad) * 48'(f1_reg.osum);
    end

    // partial products of the squares, 16-bit high and 17-bit low halves
    always_comb begin
        f3_next.dx    = f2_reg.dx;
        f3_next.dy    = f2_reg.dy;
        f3_next.x11   = 32'(f2_reg.adx[32:17]) * 32'(f2_reg.adx[32:17]);
        f3_next.y11   = 32'(f2_reg.ady[32:17]) * 32'(f2_reg.ady[32:17]);
        f3_next.x10   = 33'(f2_reg.adx[32:17]) * 33'(f2_reg.adx[16:0]);
        f3_next.y10   = 33'(f2_reg.ady[32:17]) * 33'(f2_reg.ady[16:0]);
        f3_next.x00   = 34'(f2_reg.adx[16:0]) * 34'(f2_reg.adx[16:0]);
        f3_next.y00   = 34'(f2_reg.ady[16:0]) * 34'(f2_reg.ady[16:0]);
        f3_next.coin  = f2_reg.coin;
        f3_next.trad  = f2_reg.trad;
        f3_next.eff_t = f2_reg.eff_t[47:9];
        f3_next.eff_o = f2_reg.eff_o[47:9];
    end

    always_comb begin
        logic [36:0] t;
        logic [34:0] trial;
        logic        ge;
        logic signed [XW-1:0] xi, yi;

        st_next[0].rad = (66'(f3_reg.x11) << 34) + (66'(f3_reg.x10) << 18)
                       + 66'(f3_reg.x00) + (66'(f3_reg.y11) << 34)
                       + (66'(f3_reg.y10) << 18) + 66'(f3_reg.y00);
        st_next[0].rem   = '0;
        st_next[0].root  = '0;
        st_next[0].coin  = f3_reg.coin;
        st_next[0].trad  = f3_reg.trad;
        st_next[0].eff_t = f3_reg.eff_t;
        st_next[0].eff_o = f3_reg.eff_o;
        st_next[0].ctl.dir = '0;
        // turn a left-half-plane offset by a quarter before vectoring
        if (f3_reg.dx < 0) begin
            if (f3_reg.dy >= 0) begin
                st_next[0].cx       = XW'(f3_reg.dy);
                st_next[0].cy       = -XW'(f3_reg.dx);
                st_next[0].z        = HALF_PI_Q16;
                st_next[0].ctl.quad = QUAD_POS;
            end else begin
                st_next[0].cx       = -XW'(f3_reg.dy);
                st_next[0].cy       = XW'(f3_reg.dx);
                st_next[0].z        = -HALF_PI_Q16;
                st_next[0].ctl.quad = QUAD_NEG;
            end
        end else begin
            st_next[0].cx       = XW'(f3_reg.dx);
            st_next[0].cy       = XW'(f3_reg.dy);
            st_next[0].z        = '0;
            st_next[0].ctl.quad = QUAD_NONE;
        end

        for (int k = 0; k < SQRT_STEPS; k++) begin
            st_next[k+1] = st_reg[k];
            t     = {st_reg[k].rem, st_reg[k].rad[65:64]};
            trial = {st_reg[k].root[32:0], 2'b01};
            ge    = (t >= 37'(trial));
            st_next[k+1].rem  = ge ? 35'(t - 37'(trial)) : t[34:0];
            st_next[k+1].root = {st_reg[k].root[31:0], ge};
            st_next[k+1].rad  = st_reg[k].rad << 2;
            if (k < CORDIC_STEPS) begin
                xi = st_reg[k].cx;
                yi = st_reg[k].cy;
                if (yi >= 0) begin
                    st_next[k+1].cx = xi + (yi >>> k);
                    st_next[k+1].cy = yi - (xi >>> k);
                    st_next[k+1].z  = st_reg[k].z + atan_q16(4'(k));
                    st_next[k+1].ctl.dir[k] = 1'b1;
                end else begin
                    st_next[k+1].cx = xi - (yi >>> k);
                    st_next[k+1].cy = yi + (xi >>> k);
                    st_next[k+1].z  = st_reg[k].z - atan_q16(4'(k));
                    st_next[k+1].ctl.dir[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        logic [32:0]             d;
        logic signed [LEN_W-1:0] cd, ncd;
        d      = st_reg[SQRT_STEPS].root;
        cd     = LEN_W'({8'b0, d}) - LEN_W'({2'b0, st_reg[SQRT_STEPS].eff_o});
        ncd    = LEN_W'({10'b0, st_reg[SQRT_STEPS].trad}) - LEN_W'({8'b0, d});
        h_next.hit  = (40'(d) < (40'(st_reg[SQRT_STEPS].eff_t)
                               + 40'(st_reg[SQRT_STEPS].eff_o)));
        h_next.coin = st_reg[SQRT_STEPS].coin;
        h_next.a1   = st_reg[SQRT_STEPS].coin ? 16'sd0 : round_ang(st_reg[SQRT_STEPS].z);
        h_next.a2   = round_ang(st_reg[SQRT_STEPS].coin ? PI_Q16
                                : st_reg[SQRT_STEPS].z + PI_Q16);
        h_next.c1   = sat32(ROT_W'(cd));
        h_next.c2   = sat32(ROT_W'(ncd));
        h_next.len1 = cd;
        h_next.len2 = ncd;
        h_next.ctl  = st_reg[SQRT_STEPS].ctl;
    end

    cpct_vec_rotate u_first (
        .aclk   (aclk),
        .en     (en),
        .len_in (h_reg.len1),
        .ctl_in (h_reg.ctl),
        .vec_x  (v1x),
        .vec_y  (v1y)
    );

    cpct_vec_rotate u_second (
        .aclk   (aclk),
        .en     (en),
        .len_in (h_reg.len2),
        .ctl_in (h_reg.ctl),
        .vec_x  (v2x),
        .vec_y  (v2y)
    );

    // drop everything on a miss; coincident centres skip the rotators
    always_comb begin
        out_next = '0;
        if (side_reg[VEC_LAT-1].hit) begin
            out_next.hit = 1'b1;
            out_next.a1  = side_reg[VEC_LAT-1].a1;
            out_next.a2  = side_reg[VEC_LAT-1].a2;
            if (side_reg[VEC_LAT-1].coin) begin
                out_next.x1 = side_reg[VEC_LAT-1].c1;
                out_next.x2 = side_reg[VEC_LAT-1].c2;
            end else begin
                out_next.x1 = v1x;
                out_next.y1 = v1y;
                out_next.x2 = v2x;
                out_next.y2 = v2y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            for (int k = 0; k <= SQRT_STEPS; k++) begin
                st_reg[k] <= st_next[k];
            end
            h_reg <= h_next;
            side_reg[0] <= '{hit: h_reg.hit, coin: h_reg.coin, a1: h_reg.a1,
                             a2: h_reg.a2, c1: h_reg.c1, c2: h_reg.c2};
            for (int k = 1; k < VEC_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    assign m_hit              = out_reg.hit;
    assign m_first_contact_x  = out_reg.x1;
    assign m_first_contact_y  = out_reg.y1;
    assign m_first_angle      = out_reg.a1;
    assign m_second_contact_x = out_reg.x2;
    assign m_second_contact_y = out_reg.y2;
    assign m_second_angle     = out_reg.a2;

    `CPCT_CHECK(miss_is_zero, aclk, aresetn, (m_valid && !m_hit) |-> (m_first_contact_x == 0 && m_first_contact_y == 0 && m_first_angle == 0 && m_second_contact_x == 0 && m_second_contact_y == 0 && m_second_angle == 0), "miss item carries nonzero contact data")
    `CPCT_CHECK_ALWAYS(reset_empties, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule
`default_nettype wire
